/* design/rar_pkg.sv */
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the row argmax reducer
// Holds the element type codes and the float helper functions.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam logic [1:0] TYPE_INT64 = 2'd0;
  localparam logic [1:0] TYPE_HALF  = 2'd1;
  localparam logic [1:0] TYPE_SINGLE = 2'd2;

  localparam logic [63:0] INT_SIGN   = 64'h8000000000000000;
  localparam logic [15:0] HALF_EXP   = 16'h7c00;
  localparam logic [31:0] SINGLE_EXP = 32'h7f800000;
  localparam logic [31:0] SINGLE_FRAC = 32'h007fffff;

  // binary16 to binary32 widening, exact except for NaN payloads.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sign;
    logic [4:0]  e;
    logic [9:0]  f;
    logic [3:0]  lz;
    logic [10:0] fs;
    logic [7:0]  ex;
    sign = {h[15], 31'd0};
    e = h[14:10];
    f = h[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (f[i]) lz = 4'(9 - i + 1);
    end
    fs = {1'b0, f} << lz;
    ex = 8'd113 - 8'(lz);
    if (e == 5'd31) begin
      widen_half = sign | ((f != 10'd0) ? 32'h7fc00000 : SINGLE_EXP);
    end else if (e != 5'd0) begin
      widen_half = sign | {1'b0, 8'(e) + 8'd112, f, 13'd0};
    end else if (f == 10'd0) begin
      widen_half = sign;
    end else begin
      widen_half = sign | {1'b0, ex, fs[9:0], 13'd0};
    end
  endfunction

  function automatic logic single_is_nan(input logic [31:0] x);
    single_is_nan = ((x & SINGLE_EXP) == SINGLE_EXP) && ((x & SINGLE_FRAC) != 32'd0);
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] x);
    order_key = x[31] ? ~x : (x | 32'h80000000);
  endfunction

endpackage

/* design/row_argmax_reducer.sv */
// ----------------------------------------------------------------------------
// row_argmax_reducer: streaming row argmax
// Gives the column of the first row maximum at the end of every row.
// ----------------------------------------------------------------------------
// One element is taken in every cycle while in_stall is low; the running best is
// updated in the same cycle through one compare, and the result of a row appears
// in an output register in the cycle after its last element. A new request is
// taken while that result waits, as long as the output is not also full and
// stalled. Column indices saturate at min(MAX_ROW_LEN - 1, 65535).
module row_argmax_reducer import rar_pkg::*; #(
  parameter longint MAX_ROW_LEN = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] element_value,
  input  logic        row_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] max_index
);

  localparam longint LimRaw = MAX_ROW_LEN - 1;
  localparam logic [15:0] ColLimit = (LimRaw < 65535) ? 16'(LimRaw) : 16'hffff;

  logic [1:0]  element_type;
  logic [63:0] best_value;
  logic [15:0] best_column;
  logic [15:0] column_count;
  logic [63:0] cand;
  logic [15:0] col;
  logic        wins;
  logic        take;
  logic        accept;

  assign pready = 1'b1;
  assign prdata = {30'd0, element_type};

  // Output register can refill when empty or being drained.
  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  always_comb begin
    unique case (element_type)
      TYPE_INT64: cand = element_value;
      TYPE_HALF:  cand = {48'd0, element_value[15:0]};
      default:    cand = {32'd0, element_value[31:0]};
    endcase
  end

  assign col = (column_count < ColLimit) ? column_count : ColLimit;
  assign take = (column_count == 16'd0) || wins;

  rar_compare u_cmp (
    .element_type(element_type),
    .best(best_value),
    .cand(cand),
    .wins(wins)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type <= TYPE_INT64;
      best_value <= 64'd0;
      best_column <= 16'd0;
      column_count <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) element_type <= pwdata[1:0];
      if (out_valid && !out_stall && !(accept && row_end)) out_valid <= 1'b0;
      if (accept) begin
        if (take) begin
          best_value <= cand;
          best_column <= col;
        end
        if (row_end) begin
          // The result carries the column chosen in this very cycle.
          max_index <= take ? col : best_column;
          out_valid <= 1'b1;
          column_count <= 16'd0;
        end else begin
          column_count <= (col < ColLimit) ? col + 16'd1 : ColLimit;
        end
      end
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_index))
    else $error("pending result lost");
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    column_count <= ColLimit) else $error("column count beyond limit");
  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> column_count == 16'd0) else $error("count not cleared");
`endif

endmodule

/* design/rar_compare.sv */
// ----------------------------------------------------------------------------
// rar_compare: candidate-wins decision
// Decides whether a new element replaces the stored best for the given type.
// ----------------------------------------------------------------------------
module rar_compare import rar_pkg::*; (
  input  logic [1:0]  element_type,
  input  logic [63:0] best,
  input  logic [63:0] cand,
  output logic        wins
);

  logic [31:0] b;
  logic [31:0] n;
  logic        b_nan;
  logic        n_nan;
  logic        less;

  always_comb begin
    if (element_type == TYPE_HALF) begin
      b = widen_half(best[15:0]);
      n = widen_half(cand[15:0]);
    end else begin
      b = best[31:0];
      n = cand[31:0];
    end
    b_nan = single_is_nan(b);
    n_nan = single_is_nan(n);
    less = !b_nan && !n_nan && (((b | n) & 32'h7fffffff) != 32'd0) &&
           (order_key(b) < order_key(n));
    if (element_type == TYPE_INT64) begin
      wins = (best ^ INT_SIGN) < (cand ^ INT_SIGN);
    end else begin
      wins = less || (n_nan && !b_nan);
    end
  end

endmodule
